// ----- rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Each check samples on the rising clock
// edge and is disabled while reset is high.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop)

`define ASSERT_NEXT(lbl, clk, rst, ante, cons)

`endif

`endif

// ----- rtl/ctp_pkg.sv -----
package ctp_pkg;

  localparam int unsigned SEGMENTS_DEF = 16;
  localparam int unsigned COORD_W      = 32;
  localparam int unsigned IDX_W        = 5;
  localparam int unsigned TOL_W        = 31;
  localparam int unsigned OP_W         = 2;
  localparam logic [TOL_W-1:0] TOL_RESET = TOL_W'(65536);

  typedef enum logic [OP_W-1:0] {
    OP_PLAN    = 2'd0,
    OP_CHECK   = 2'd1,
    OP_ADVANCE = 2'd2
  } op_e;

  typedef logic signed [COORD_W-1:0] coord_t;

  typedef struct packed {
    logic [OP_W-1:0] op;
    coord_t          pos_x;
    coord_t          pos_y;
    coord_t          pos_z;
    coord_t          goal_x;
    coord_t          goal_y;
    coord_t          goal_z;
  } item_t;

  typedef struct packed {
    coord_t           point_x;
    coord_t           point_y;
    coord_t           point_z;
    logic             reached;
    logic [IDX_W-1:0] point_index;
  } result_t;

  typedef struct packed {
    logic load_item;
    logic calc_diff;
    logic calc_point;
    logic load_out;
  } cmd_t;

  typedef struct packed {
    logic out_free;
  } status_t;

endpackage

// ----- rtl/ctp_item_if.sv -----
interface ctp_item_if;
  import ctp_pkg::*;

  logic            valid;
  logic            ready;
  logic [OP_W-1:0] op;
  coord_t          pos_x;
  coord_t          pos_y;
  coord_t          pos_z;
  coord_t          goal_x;
  coord_t          goal_y;
  coord_t          goal_z;

  modport source (output valid, output op, output pos_x, output pos_y, output pos_z,
                  output goal_x, output goal_y, output goal_z, input ready);
  modport sink (input valid, input op, input pos_x, input pos_y, input pos_z,
                input goal_x, input goal_y, input goal_z, output ready);
endinterface

// ----- rtl/ctp_result_if.sv -----
interface ctp_result_if;
  import ctp_pkg::*;

  logic             valid;
  logic             ready;
  coord_t           point_x;
  coord_t           point_y;
  coord_t           point_z;
  logic             reached;
  logic [IDX_W-1:0] point_index;

  modport source (output valid, output point_x, output point_y, output point_z,
                  output reached, output point_index, input ready);
  modport sink (input valid, input point_x, input point_y, input point_z,
                input reached, input point_index, output ready);
endinterface

// ----- rtl/ctp_cfg_if.sv -----
interface ctp_cfg_if;
  import ctp_pkg::*;

  logic             valid;
  logic             ready;
  logic [TOL_W-1:0] reach_tolerance;

  modport source (output valid, output reach_tolerance, input ready);
  modport sink (input valid, input reach_tolerance, output ready);
endinterface

// ----- rtl/ctp_ctrl.sv -----
module ctp_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             item_valid,
  output logic             item_ready,
  output ctp_pkg::cmd_t    cmd,
  input  ctp_pkg::status_t status
);
  import ctp_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_DIFF  = 4'b0010,
    ST_POINT = 4'b0100,
    ST_OUT   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    item_ready = 1'b0;
    unique case (state)
      ST_IDLE: begin
        // No transfer is taken while reset is high.
        item_ready = !rst;
        if (item_valid && !rst) begin
          cmd.load_item = 1'b1;
          state_next    = ST_DIFF;
        end
      end
      ST_DIFF: begin
        cmd.calc_diff = 1'b1;
        state_next    = ST_POINT;
      end
      ST_POINT: begin
        cmd.calc_point = 1'b1;
        state_next     = ST_OUT;
      end
      ST_OUT: begin
        // The result register may still hold an earlier result; wait for its transfer.
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

// ----- rtl/ctp_datapath.sv -----
module ctp_datapath #(
  parameter int unsigned SEGMENTS = ctp_pkg::SEGMENTS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  input  ctp_pkg::cmd_t               cmd,
  output ctp_pkg::status_t            status,
  input  ctp_pkg::item_t              item,
  input  logic                        cfg_we,
  input  logic [ctp_pkg::TOL_W-1:0]   cfg_tol,
  output logic                        out_valid,
  input  logic                        out_ready,
  output ctp_pkg::result_t            out_data
);
  import ctp_pkg::*;

  localparam int unsigned HALF    = SEGMENTS / 2;
  localparam int unsigned SHAMT_W = $clog2(SEGMENTS - HALF + 1);
  localparam logic [IDX_W-1:0] SEG_IDX  = IDX_W'(SEGMENTS);
  localparam logic [IDX_W-1:0] HALF_IDX = IDX_W'(HALF);

  typedef enum logic [1:0] {
    SEL_START,
    SEL_GOAL,
    SEL_FROM_START,
    SEL_FROM_GOAL
  } sel_t;

  logic [TOL_W-1:0]      tol;
  coord_t                start [3];
  coord_t                goal  [3];
  logic [IDX_W-1:0]      index;
  logic [OP_W-1:0]       op_q;
  coord_t                pos_q [3];
  logic signed [32:0]    diff_q [3];
  sel_t                  sel_q;
  logic [SHAMT_W-1:0]    shamt_q;
  coord_t                point_q [3];

  sel_t                  sel_next;
  logic [SHAMT_W-1:0]    shamt_next;
  coord_t                point_next [3];
  logic [2:0]            close;

  assign status.out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      tol <= TOL_RESET;
    end else if (cfg_we) begin
      tol <= cfg_tol;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int a = 0; a < 3; a++) begin
        start[a] <= '0;
        goal[a]  <= '0;
      end
      index <= '0;
    end else if (cmd.load_item) begin
      if (item.op == OP_PLAN) begin
        start[0] <= item.pos_x;
        start[1] <= item.pos_y;
        start[2] <= item.pos_z;
        goal[0]  <= item.goal_x;
        goal[1]  <= item.goal_y;
        goal[2]  <= item.goal_z;
        index    <= '0;
      end else if (item.op == OP_ADVANCE && index < SEG_IDX) begin
        index <= index + IDX_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      op_q     <= item.op;
      pos_q[0] <= item.pos_x;
      pos_q[1] <= item.pos_y;
      pos_q[2] <= item.pos_z;
    end
  end

  // Pick which end the checkpoint is measured from and by how far diff is shifted.
  always_comb begin
    sel_next   = SEL_FROM_GOAL;
    shamt_next = SHAMT_W'(index - HALF_IDX + IDX_W'(1));
    if (index == '0) begin
      sel_next = SEL_START;
    end else if (index >= SEG_IDX) begin
      sel_next = SEL_GOAL;
    end else if (index < HALF_IDX) begin
      sel_next   = SEL_FROM_START;
      shamt_next = SHAMT_W'(HALF_IDX - index + IDX_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_diff) begin
      for (int a = 0; a < 3; a++) begin
        diff_q[a] <= {goal[a][COORD_W-1], goal[a]} - {start[a][COORD_W-1], start[a]};
      end
      sel_q   <= sel_next;
      shamt_q <= shamt_next;
    end
  end

  // Both operands must be signed so that the shift of diff fills with its sign.
  always_comb begin
    for (int a = 0; a < 3; a++) begin
      point_next[a] = start[a];
      case (sel_q)
        SEL_START:      point_next[a] = start[a];
        SEL_GOAL:       point_next[a] = goal[a];
        SEL_FROM_START: point_next[a] =
          COORD_W'($signed({start[a][COORD_W-1], start[a]}) + (diff_q[a] >>> shamt_q));
        SEL_FROM_GOAL:  point_next[a] =
          COORD_W'($signed({goal[a][COORD_W-1], goal[a]}) - (diff_q[a] >>> shamt_q));
        default:        point_next[a] = start[a];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.calc_point) begin
      for (int a = 0; a < 3; a++) begin
        point_q[a] <= point_next[a];
      end
    end
  end

  // |d| < tol is checked as -tol < d < tol, with the coordinates sign-extended and tol zero-extended to 34 bits.
  always_comb begin
    logic signed [33:0] d;
    logic signed [33:0] t;
    for (int a = 0; a < 3; a++) begin
      d = {{2{point_q[a][COORD_W-1]}}, point_q[a]} - {{2{pos_q[a][COORD_W-1]}}, pos_q[a]};
      t = {3'b000, tol};
      close[a] = (d < t) && (d > -t);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      out_data.point_x     <= point_q[0];
      out_data.point_y     <= point_q[1];
      out_data.point_z     <= point_q[2];
      out_data.reached     <= (op_q == OP_CHECK) && (&close);
      out_data.point_index <= index;
    end
  end

endmodule

// ----- rtl/checkpoint_trajectory_planner.sv -----
// Channel  | Dir | Payload
// ---------+-----+--------------------------------------------------------
// item     | in  | op, pos_x, pos_y, pos_z, goal_x, goal_y, goal_z
// result   | out | point_x, point_y, point_z, reached, point_index
// cfg      | in  | reach_tolerance
//
// Each item steps through accept and state update, axis difference,
// shift and add for the checkpoint, then tolerance compare into the result register.
// A new item is taken in the cycle after its predecessor's result is loaded.
// A result waiting on result.ready holds the following item in its final step.
// Synchronous reset clears the saved path, the index and the tolerance (to 1.0).
// Configuration transfers are taken in every cycle outside reset.
`include "assert_macros.svh"

module checkpoint_trajectory_planner #(
  parameter int unsigned SEGMENTS = ctp_pkg::SEGMENTS_DEF
) (
  input  logic           clk,
  input  logic           rst,
  ctp_item_if.sink       item,
  ctp_result_if.source   result,
  ctp_cfg_if.sink        cfg
);
  import ctp_pkg::*;

  cmd_t    cmd;
  status_t status;
  item_t   item_data;
  result_t out_data;
  logic    out_valid;

  assign item_data.op     = item.op;
  assign item_data.pos_x  = item.pos_x;
  assign item_data.pos_y  = item.pos_y;
  assign item_data.pos_z  = item.pos_z;
  assign item_data.goal_x = item.goal_x;
  assign item_data.goal_y = item.goal_y;
  assign item_data.goal_z = item.goal_z;

  assign cfg.ready = !rst;

  ctp_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item.valid),
    .item_ready (item.ready),
    .cmd        (cmd),
    .status     (status)
  );

  ctp_datapath #(
    .SEGMENTS (SEGMENTS)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .status    (status),
    .item      (item_data),
    .cfg_we    (cfg.valid && cfg.ready),
    .cfg_tol   (cfg.reach_tolerance),
    .out_valid (out_valid),
    .out_ready (result.ready),
    .out_data  (out_data)
  );

  assign result.valid       = out_valid;
  assign result.point_x     = out_data.point_x;
  assign result.point_y     = out_data.point_y;
  assign result.point_z     = out_data.point_z;
  assign result.reached     = out_data.reached;
  assign result.point_index = out_data.point_index;

  `ASSERT_ALWAYS(a_index_range, clk, rst, result.valid |-> (result.point_index <= IDX_W'(SEGMENTS)))
  `ASSERT_NEXT(a_busy_after_accept, clk, rst, item.valid && item.ready, !item.ready)
  `ASSERT_NEXT(a_result_held, clk, rst, result.valid && !result.ready, result.valid)

endmodule

// ----- tb/sv/tb_top.sv -----
module tb_top;
  import ctp_pkg::*;

  localparam int unsigned SEGMENTS = SEGMENTS_DEF;
  localparam int unsigned CYCLE_LIMIT = 300000;
  localparam int unsigned SETTLE_CYCLES = 10;
  localparam int unsigned PHASE_ITEMS = 140;
  localparam int unsigned PHASES = 6;
  localparam coord_t C_MIN = 32'sh8000_0000;
  localparam coord_t C_MAX = 32'sh7FFF_FFFF;
  localparam coord_t C_ONE = 32'sh0001_0000;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(SEGMENTS);
  // Op code left unused by the block; it must only report the current checkpoint.
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct {
    item_t   it;
    int      reps;
    bit      typed;
    result_t want;
  } stim_row_t;

  logic clk;
  logic rst;

  ctp_item_if   item_ch ();
  ctp_result_if result_ch ();
  ctp_cfg_if    cfg_ch ();

  checkpoint_trajectory_planner #(
    .SEGMENTS (SEGMENTS)
  ) i_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // Shadow of the planner state.
  logic [TOL_W-1:0] tolerance = TOL_RESET;
  coord_t           path_start [3] = '{default: '0};
  coord_t           path_goal [3] = '{default: '0};
  logic [IDX_W-1:0] cur_index = '0;

  result_t     pending_points [$];
  int unsigned send_idle = 20;
  int unsigned recv_stall = 20;
  int unsigned errors = 0;
  int unsigned cycle_count = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // Checkpoint j lies on the start side for j below M/2 and on the goal side
  // from M/2 on; the span is taken 33 bits wide and shifted arithmetically.
  function automatic coord_t checkpoint_coord(coord_t s, coord_t g, int unsigned j);
    logic signed [32:0] s33;
    logic signed [32:0] g33;
    logic signed [32:0] span;
    int unsigned        half;
    s33 = $signed({s[31], s});
    g33 = $signed({g[31], g});
    span = g33 - s33;
    half = SEGMENTS / 2;
    if (j == 0) return s;
    if (j >= SEGMENTS) return g;
    if (j < half) return coord_t'(s33 + (span >>> (half - j + 1)));
    return coord_t'(g33 - (span >>> (j - half + 1)));
  endfunction

  function automatic bit within_reach(coord_t p, coord_t q);
    logic signed [33:0] gap;
    gap = $signed({{2{p[31]}}, p}) - $signed({{2{q[31]}}, q});
    if (gap < 0) gap = -gap;
    return gap < $signed({3'b000, tolerance});
  endfunction

  function automatic result_t follow_path(item_t it);
    result_t r;
    case (it.op)
      OP_PLAN: begin
        path_start[0] = it.pos_x;
        path_start[1] = it.pos_y;
        path_start[2] = it.pos_z;
        path_goal[0] = it.goal_x;
        path_goal[1] = it.goal_y;
        path_goal[2] = it.goal_z;
        cur_index = '0;
      end
      OP_ADVANCE: begin
        if (cur_index < SEGMENTS) cur_index = cur_index + 1'b1;
      end
      default: ;
    endcase
    r.point_x = checkpoint_coord(path_start[0], path_goal[0], cur_index);
    r.point_y = checkpoint_coord(path_start[1], path_goal[1], cur_index);
    r.point_z = checkpoint_coord(path_start[2], path_goal[2], cur_index);
    r.reached = (it.op == OP_CHECK) && within_reach(r.point_x, it.pos_x) &&
                within_reach(r.point_y, it.pos_y) && within_reach(r.point_z, it.pos_z);
    r.point_index = cur_index;
    return r;
  endfunction

  function automatic coord_t rand_coord();
    case ($urandom_range(3))
      0: return coord_t'($urandom);
      1: return coord_t'(int'($urandom_range(0, 400 * 65536)) - 200 * 65536);
      2: begin
        case ($urandom_range(3))
          0: return C_MIN;
          1: return C_MAX;
          2: return '0;
          default: return '1;
        endcase
      end
      default: return coord_t'($signed($urandom) >>> $urandom_range(31));
    endcase
  endfunction

  // Mostly advances and checks close to the current checkpoint, with an
  // occasional new plan, so that the index walks deep into each path.
  function automatic item_t random_item();
    item_t       it;
    int unsigned pick;
    int unsigned span;
    int          off;
    coord_t      near [3];
    it.pos_x = rand_coord();
    it.pos_y = rand_coord();
    it.pos_z = rand_coord();
    it.goal_x = rand_coord();
    it.goal_y = rand_coord();
    it.goal_z = rand_coord();
    pick = $urandom_range(99);
    if (pick < 6) begin
      it.op = OP_PLAN;
    end else if (pick < 50) begin
      it.op = OP_ADVANCE;
    end else begin
      it.op = OP_CHECK;
      if ($urandom_range(9) < 7) begin
        span = (tolerance > 31'h00FF_FFFF) ? 32'h00FF_FFFF : 32'(tolerance);
        for (int a = 0; a < 3; a++) begin
          off = int'($urandom_range(0, 2 * span + 2)) - int'(span) - 1;
          near[a] = checkpoint_coord(path_start[a], path_goal[a], cur_index) + coord_t'(off);
        end
        it.pos_x = near[0];
        it.pos_y = near[1];
        it.pos_z = near[2];
      end
    end
    return it;
  endfunction

  function automatic item_t mk_item(logic [OP_W-1:0] op, coord_t px, coord_t py, coord_t pz,
                                    coord_t gx, coord_t gy, coord_t gz);
    item_t it;
    it.op = op;
    it.pos_x = px;
    it.pos_y = py;
    it.pos_z = pz;
    it.goal_x = gx;
    it.goal_y = gy;
    it.goal_z = gz;
    return it;
  endfunction

  function automatic result_t mk_point(coord_t x, coord_t y, coord_t z, logic hit,
                                       logic [IDX_W-1:0] idx);
    result_t r;
    r.point_x = x;
    r.point_y = y;
    r.point_z = z;
    r.reached = hit;
    r.point_index = idx;
    return r;
  endfunction

  // Called just after a falling edge; returns just after a falling edge, once the item has been accepted.
  task automatic put_item(item_t it, bit typed, result_t want);
    result_t predicted;
    while ($urandom_range(99) < send_idle) begin
      item_ch.valid <= 1'b0;
      @(negedge clk);
    end
    item_ch.valid <= 1'b1;
    item_ch.op <= it.op;
    item_ch.pos_x <= it.pos_x;
    item_ch.pos_y <= it.pos_y;
    item_ch.pos_z <= it.pos_z;
    item_ch.goal_x <= it.goal_x;
    item_ch.goal_y <= it.goal_y;
    item_ch.goal_z <= it.goal_z;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    predicted = follow_path(it);
    pending_points.push_back(typed ? want : predicted);
    @(negedge clk);
  endtask

  task automatic write_tolerance(logic [TOL_W-1:0] value);
    item_ch.valid <= 1'b0;
    while (pending_points.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.reach_tolerance <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    tolerance = value;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic compare_field(string field, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, actual %0h", field, want, got);
      errors++;
    end
  endtask

  initial begin
    result_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      result_ch.ready <= ($urandom_range(99) >= recv_stall);
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (pending_points.size() == 0) begin
        $error("result transfer with no expected checkpoint waiting");
        errors++;
      end else begin
        want = pending_points.pop_front();
        compare_field("point_x", want.point_x, result_ch.point_x);
        compare_field("point_y", want.point_y, result_ch.point_y);
        compare_field("point_z", want.point_z, result_ch.point_z);
        compare_field("reached", 32'(want.reached), 32'(result_ch.reached));
        compare_field("point_index", 32'(want.point_index), 32'(result_ch.point_index));
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("** checkpoint_trajectory_planner: FAILED **");
      $finish;
    end
  end

  initial begin
    stim_row_t        directed [$];
    result_t          none;
    logic [TOL_W-1:0] phase_tol;
    none = '0;
    rst = 1'b1;
    item_ch.valid = 1'b0;
    item_ch.op = OP_PLAN;
    item_ch.pos_x = '0;
    item_ch.pos_y = '0;
    item_ch.pos_z = '0;
    item_ch.goal_x = '0;
    item_ch.goal_y = '0;
    item_ch.goal_z = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.reach_tolerance = '0;

    // After reset the path is all zero and the tolerance is 1.0; a distance
    // equal to the tolerance does not count as reached.
    directed.push_back('{mk_item(OP_CHECK, 0, 0, 0, 0, 0, 0), 1, 1,
                         mk_point(0, 0, 0, 1'b1, 0)});
    directed.push_back('{mk_item(OP_CHECK, C_ONE, 0, 0, C_MAX, C_MIN, -1), 1, 1,
                         mk_point(0, 0, 0, 1'b0, 0)});
    directed.push_back('{mk_item(OP_CHECK, C_ONE - 1, 1 - C_ONE, 0, 0, 0, 0), 1, 1,
                         mk_point(0, 0, 0, 1'b1, 0)});
    directed.push_back('{mk_item(OP_UNUSED, 0, 0, 0, 0, 0, 0), 1, 1,
                         mk_point(0, 0, 0, 1'b0, 0)});
    directed.push_back('{mk_item(OP_PLAN, C_MIN, C_MAX, 0, C_MAX, C_MIN, -1), 1, 1,
                         mk_point(C_MIN, C_MAX, 0, 1'b0, 0)});
    directed.push_back('{mk_item(OP_ADVANCE, 0, 0, 0, 0, 0, 0), SEGMENTS, 0, none});
    // Advancing at the goal holds the index at the last checkpoint.
    directed.push_back('{mk_item(OP_ADVANCE, -1, -1, -1, -1, -1, -1), 2, 1,
                         mk_point(C_MAX, C_MIN, -1, 1'b0, LAST_IDX)});
    directed.push_back('{mk_item(OP_CHECK, C_MAX - C_ONE + 1, C_MIN + C_ONE - 1, -1,
                                 0, 0, 0), 1, 1,
                         mk_point(C_MAX, C_MIN, -1, 1'b1, LAST_IDX)});
    directed.push_back('{mk_item(OP_CHECK, C_MIN, C_MAX, 0, 0, 0, 0), 1, 1,
                         mk_point(C_MAX, C_MIN, -1, 1'b0, LAST_IDX)});
    directed.push_back('{mk_item(OP_UNUSED, C_MAX, C_MIN, -1, C_MIN, C_MAX, 0), 1, 1,
                         mk_point(C_MAX, C_MIN, -1, 1'b0, LAST_IDX)});
    // Tiny spans exercise the rounding of the shifts toward minus infinity.
    directed.push_back('{mk_item(OP_PLAN, 1, -1, 7, -1, 1, -7), 1, 0, none});
    directed.push_back('{mk_item(OP_ADVANCE, 0, 0, 0, 0, 0, 0), 3, 0, none});
    directed.push_back('{mk_item(OP_CHECK, 0, 0, 0, 0, 0, 0), 1, 0, none});
    directed.push_back('{mk_item(OP_PLAN, -1, -1, -1, -1, -1, -1), 1, 1,
                         mk_point(-1, -1, -1, 1'b0, 0)});

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed[r]) begin
      for (int n = 0; n < directed[r].reps; n++) begin
        put_item(directed[r].it, directed[r].typed, directed[r].want);
      end
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      case (ph)
        0: phase_tol = '0;
        1: phase_tol = '1;
        2: phase_tol = TOL_W'(1);
        3: phase_tol = TOL_W'($urandom);
        4: phase_tol = TOL_RESET;
        default: phase_tol = TOL_W'($urandom_range(1, 4 * 65536));
      endcase
      write_tolerance(phase_tol);
      send_idle = (ph == 2) ? 0 : 20;
      recv_stall = (ph == 2) ? 0 : 20;
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        put_item(random_item(), 1'b0, none);
      end
    end

    item_ch.valid <= 1'b0;
    while (pending_points.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("** checkpoint_trajectory_planner: PASSED **");
    end else begin
      $display("** checkpoint_trajectory_planner: FAILED **");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
+incdir+rtl
rtl/ctp_pkg.sv
rtl/ctp_item_if.sv
rtl/ctp_result_if.sv
rtl/ctp_cfg_if.sv
rtl/ctp_ctrl.sv
rtl/ctp_datapath.sv
rtl/checkpoint_trajectory_planner.sv
tb/sv/tb_top.sv
